### design/csk_pkg.sv
// ----------------------------------------------------------------------------
// csk_pkg: shared types and constants for the subgrid sum counter
// Register map, field widths, configuration bundle and engine states.
// ----------------------------------------------------------------------------
package csk_pkg;

    // default grid capacity
    localparam int MAX_ROWS_DEF = 64;
    localparam int MAX_COLS_DEF = 64;

    // field widths
    localparam int GRID_W   = 7;
    localparam int TARGET_W = 13;
    localparam int COUNT_W  = 23;

    // APB port
    localparam int PADDR_W = 4;
    localparam int APB_DW  = 32;

    // register indexes (byte address bits [3:2])
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_GRID_ROWS  = 2'd0;
    localparam reg_idx_t REG_GRID_COLS  = 2'd1;
    localparam reg_idx_t REG_TARGET_SUM = 2'd2;

    // register reset values
    localparam logic [GRID_W-1:0]   GRID_ROWS_RST  = 7'd64;
    localparam logic [GRID_W-1:0]   GRID_COLS_RST  = 7'd64;
    localparam logic [TARGET_W-1:0] TARGET_SUM_RST = 13'd0;

    // configuration bundle, register file to engine
    typedef struct packed {
        logic [GRID_W-1:0]   grid_rows;
        logic [GRID_W-1:0]   grid_cols;
        logic [TARGET_W-1:0] target_sum;
        logic                restart;
    } cfg_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_LOAD,
        ST_LWR,
        ST_SWEEP,
        ST_SDRAIN,
        ST_CLEAR,
        ST_CDRAIN,
        ST_EMIT
    } eng_state_t;

endpackage

### design/csk_if.sv
// ----------------------------------------------------------------------------
// csk_if: valid/ready channels of the subgrid sum counter
// Cell input channel and count result channel.
// ----------------------------------------------------------------------------
interface csk_cell_if;
    logic valid;
    logic ready;
    logic cell_bit;

    modport source (output valid, output cell_bit, input ready);
    modport sink   (input valid, input cell_bit, output ready);
endinterface

interface csk_count_if;
    import csk_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] subgrid_count;

    modport source (output valid, output subgrid_count, input ready);
    modport sink   (input valid, input subgrid_count, output ready);
endinterface

### design/count_subgrids_with_sum_k.sv
// ----------------------------------------------------------------------------
// count_subgrids_with_sum_k: counts subgrids of a binary grid with sum K
// Top level: APB register file plus the prefix-store counting engine.
// ----------------------------------------------------------------------------
// Usage:
//   cell_in   - one grid cell per beat, row-major; cell_bit = 1 for a set cell.
//   count_out - one beat per grid: number of subgrids whose ones total
//               equals target_sum, modulo 2^23.
//   APB       - grid_rows @0x0, grid_cols @0x4, target_sum @0x8. Any write
//               to these restarts loading at the first cell. Write only
//               while idle.
// Sequence:
//   Loading reads the prefix store for each cell, then writes it back.
//   After the last cell the engine walks every row pair top <= bottom;
//   each pair runs one column sweep through the count table (3-stage
//   read/modify/write with forwarding), a second sweep that zeroes the
//   touched table entries, and the reset of entry zero. The count table
//   port is the limit. A full 64x64 grid runs 2080 pairs.
// Reset:
//   A clearing pass over all MAX_ROWS*MAX_COLS+1 entries (4097 at defaults)
//   fills the count table; cell_in.ready stays low until it ends.
// Stall:
//   The result sits in an output register; the next grid loads while it
//   waits. A second result holds the engine until the first is taken.
// ----------------------------------------------------------------------------
module count_subgrids_with_sum_k #(
    parameter int MAX_ROWS = csk_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = csk_pkg::MAX_COLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csk_pkg::PADDR_W-1:0]  paddr,
    input  logic [csk_pkg::APB_DW-1:0]   pwdata,
    output logic [csk_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    csk_cell_if.sink                     cell_in,
    csk_count_if.source                  count_out
);
    import csk_pkg::*;

    cfg_t cfg;

    // register file; restart pulses on every mapped write
    csk_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // prefix store, count table, load and sweep control
    csk_engine #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .cell_in   (cell_in),
        .count_out (count_out)
    );

endmodule

### design/csk_cfg.sv
// ----------------------------------------------------------------------------
// csk_cfg: APB register file
// Holds grid size and target sum; flags a restart on every mapped write.
// ----------------------------------------------------------------------------
module csk_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csk_pkg::PADDR_W-1:0]  paddr,
    input  logic [csk_pkg::APB_DW-1:0]   pwdata,
    output logic [csk_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    output csk_pkg::cfg_t                cfg
);
    import csk_pkg::*;

    logic [GRID_W-1:0]   grid_rows_reg, grid_rows_next;
    logic [GRID_W-1:0]   grid_cols_reg, grid_cols_next;
    logic [TARGET_W-1:0] target_sum_reg, target_sum_next;
    logic                wr_en;
    logic                restart;
    reg_idx_t            reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[PADDR_W-1:2];

    always_comb
    begin
        grid_rows_next  = grid_rows_reg;
        grid_cols_next  = grid_cols_reg;
        target_sum_next = target_sum_reg;
        restart         = 1'b0;
        if (wr_en)
        begin
            case (reg_idx)
                REG_GRID_ROWS:
                begin
                    grid_rows_next = pwdata[GRID_W-1:0];
                    restart        = 1'b1;
                end
                REG_GRID_COLS:
                begin
                    grid_cols_next = pwdata[GRID_W-1:0];
                    restart        = 1'b1;
                end
                REG_TARGET_SUM:
                begin
                    target_sum_next = pwdata[TARGET_W-1:0];
                    restart         = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_rows_reg  <= GRID_ROWS_RST;
            grid_cols_reg  <= GRID_COLS_RST;
            target_sum_reg <= TARGET_SUM_RST;
        end
        else
        begin
            grid_rows_reg  <= grid_rows_next;
            grid_cols_reg  <= grid_cols_next;
            target_sum_reg <= target_sum_next;
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_GRID_ROWS:  prdata = APB_DW'(grid_rows_reg);
            REG_GRID_COLS:  prdata = APB_DW'(grid_cols_reg);
            REG_TARGET_SUM: prdata = APB_DW'(target_sum_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.grid_rows  = grid_rows_reg;
    assign cfg.grid_cols  = grid_cols_reg;
    assign cfg.target_sum = target_sum_reg;
    assign cfg.restart    = restart;

endmodule

### design/csk_engine.sv
// ----------------------------------------------------------------------------
// csk_engine: prefix-sum store, count table and the row-pair sweep
// Loads cells into the prefix store, then counts subgrids per row pair.
// ----------------------------------------------------------------------------
module csk_engine #(
    parameter int MAX_ROWS = csk_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = csk_pkg::MAX_COLS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  csk_pkg::cfg_t cfg,
    csk_cell_if.sink      cell_in,
    csk_count_if.source   count_out
);
    import csk_pkg::*;

    localparam int RW        = $clog2(MAX_ROWS + 1);
    localparam int CLW       = $clog2(MAX_COLS + 1);
    localparam int RIW       = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CIW       = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int PAW       = RIW + CIW;
    localparam int PF_DEPTH  = 2 ** PAW;
    localparam int SUM_DEPTH = MAX_ROWS * MAX_COLS + 1;
    localparam int PW        = $clog2(SUM_DEPTH);
    localparam int CNW       = $clog2(MAX_COLS + 2);
    localparam int RSW       = $clog2(MAX_COLS + 1);
    localparam int XW        = (PW > TARGET_W) ? PW : TARGET_W;

    eng_state_t state_reg, state_next;

    // memories
    logic [PW-1:0]  pf_mem [PF_DEPTH];
    logic [CNW-1:0] ct_mem [SUM_DEPTH];
    logic [PW-1:0]  pf_rd_a_reg, pf_rd_b_reg;
    logic [CNW-1:0] ct_rd_a_reg, ct_rd_b_reg;

    // control registers
    logic [PW-1:0]      init_addr_reg, init_addr_next;
    logic [RIW-1:0]     row_reg, row_next;
    logic [CIW-1:0]     col_reg, col_next;
    logic [RSW-1:0]     rowsum_reg, rowsum_next;
    logic               lw_last_reg, lw_last_next;
    logic [RIW-1:0]     top_reg, top_next;
    logic [RIW-1:0]     bot_reg, bot_next;
    logic [CIW-1:0]     wcnt_reg, wcnt_next;
    logic               vb_reg, vb_next;
    logic               vc_reg, vc_next;
    logic               fwd_valid_reg, fwd_valid_next;
    logic [COUNT_W-1:0] total_reg, total_next;
    logic               out_valid_reg, out_valid_next;

    // payload registers
    logic [PAW-1:0]     lw_addr_reg, lw_addr_next;
    logic [RSW-1:0]     lw_sum_reg, lw_sum_next;
    logic               lw_row0_reg, lw_row0_next;
    logic               b_clear_reg, b_clear_next;
    logic               b_top0_reg, b_top0_next;
    logic [PW-1:0]      s_c_reg, s_c_next;
    logic [PW-1:0]      sk_c_reg, sk_c_next;
    logic               ge_c_reg, ge_c_next;
    logic [PW-1:0]      fwd_addr_reg, fwd_addr_next;
    logic [CNW-1:0]     fwd_data_reg, fwd_data_next;
    logic [COUNT_W-1:0] out_data_reg, out_data_next;

    // combinational
    logic [RW-1:0]  rows_eff;
    logic [CLW-1:0] cols_eff;
    logic [RIW-1:0] rows_m1;
    logic [CIW-1:0] cols_m1;
    logic           cell_acc;
    logic           col_last;
    logic           pair_last;
    logic           out_free;
    logic           issue;
    logic [RSW-1:0] rowsum_inc;
    logic [PAW-1:0] pf_ra, pf_rb;
    logic           pf_we;
    logic [PW-1:0]  pf_wdata;
    logic [PW-1:0]  pb_val;
    logic [PW-1:0]  s_b;
    logic [PW-1:0]  sk_b;
    logic           ge_b;
    logic [CNW-1:0] cnt_s, cnt_k;
    logic           ct_we;
    logic [PW-1:0]  ct_waddr;
    logic [CNW-1:0] ct_wdata;

    // grid size, zero counts as one and oversize saturates
    always_comb
    begin
        if (cfg.grid_rows == '0)
            rows_eff = RW'(1);
        else if (int'(cfg.grid_rows) > MAX_ROWS)
            rows_eff = RW'(MAX_ROWS);
        else
            rows_eff = RW'(cfg.grid_rows);
        if (cfg.grid_cols == '0)
            cols_eff = CLW'(1);
        else if (int'(cfg.grid_cols) > MAX_COLS)
            cols_eff = CLW'(MAX_COLS);
        else
            cols_eff = CLW'(cfg.grid_cols);
    end

    assign rows_m1   = RIW'(rows_eff - RW'(1));
    assign cols_m1   = CIW'(cols_eff - CLW'(1));
    assign cell_acc  = cell_in.valid & cell_in.ready;
    assign col_last  = (wcnt_reg == cols_m1);
    assign pair_last = (top_reg == rows_m1) && (bot_reg == rows_m1);
    assign out_free  = !out_valid_reg || count_out.ready;
    assign issue     = (state_reg == ST_SWEEP) || (state_reg == ST_CLEAR);
    assign rowsum_inc = RSW'(rowsum_reg + RSW'(cell_in.cell_bit));

    assign cell_in.ready           = (state_reg == ST_LOAD);
    assign count_out.valid         = out_valid_reg;
    assign count_out.subgrid_count = out_data_reg;

    // pf ports: load reads the cell above, sweep reads bottom row and row above top
    assign pf_ra = (state_reg == ST_LOAD) ? {RIW'(row_reg - 1'b1), col_reg}
                                          : {bot_reg, wcnt_reg};
    assign pf_rb = {RIW'(top_reg - 1'b1), wcnt_reg};
    assign pf_we    = (state_reg == ST_LWR);
    assign pf_wdata = (lw_row0_reg ? '0 : pf_rd_a_reg) + PW'(lw_sum_reg);

    // stage B: column sum of the row band, count table lookups
    assign pb_val = b_top0_reg ? '0 : pf_rd_b_reg;
    assign s_b    = pf_rd_a_reg - pb_val;
    assign ge_b   = (XW'(s_b) >= XW'(cfg.target_sum));
    assign sk_b   = PW'(XW'(s_b) - XW'(cfg.target_sum));

    // stage C: forward the previous column's write
    assign cnt_s = (fwd_valid_reg && (fwd_addr_reg == s_c_reg)) ? fwd_data_reg : ct_rd_a_reg;
    assign cnt_k = (fwd_valid_reg && (fwd_addr_reg == sk_c_reg)) ? fwd_data_reg : ct_rd_b_reg;

    // count table write port
    always_comb
    begin
        ct_we    = 1'b0;
        ct_waddr = s_c_reg;
        ct_wdata = CNW'(cnt_s + 1'b1);
        if (state_reg == ST_INIT)
        begin
            ct_we    = 1'b1;
            ct_waddr = init_addr_reg;
            ct_wdata = (init_addr_reg == '0) ? CNW'(1) : '0;
        end
        else if (vc_reg)
        begin
            ct_we = 1'b1;
        end
        else if (vb_reg && b_clear_reg)
        begin
            ct_we    = 1'b1;
            ct_waddr = s_b;
            ct_wdata = '0;
        end
        else if (state_reg == ST_CDRAIN)
        begin
            ct_we    = 1'b1;
            ct_waddr = '0;
            ct_wdata = CNW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (pf_we)
            pf_mem[lw_addr_reg] <= pf_wdata;
        pf_rd_a_reg <= pf_mem[pf_ra];
        pf_rd_b_reg <= pf_mem[pf_rb];
    end

    always_ff @(posedge clk)
    begin
        if (ct_we)
            ct_mem[ct_waddr] <= ct_wdata;
        ct_rd_a_reg <= ct_mem[s_b];
        ct_rd_b_reg <= ct_mem[sk_b];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_INIT:   if (init_addr_reg == PW'(SUM_DEPTH - 1)) state_next = ST_LOAD;
            ST_LOAD:   if (cell_acc) state_next = ST_LWR;
            ST_LWR:    state_next = lw_last_reg ? ST_SWEEP : ST_LOAD;
            ST_SWEEP:  if (col_last) state_next = ST_SDRAIN;
            ST_SDRAIN: if (!vb_reg) state_next = ST_CLEAR;
            ST_CLEAR:  if (col_last) state_next = ST_CDRAIN;
            ST_CDRAIN: if (!vb_reg) state_next = pair_last ? ST_EMIT : ST_SWEEP;
            ST_EMIT:   if (out_free) state_next = ST_LOAD;
            default:   state_next = ST_INIT;
        endcase
    end

    // datapath and counters
    always_comb
    begin
        init_addr_next = init_addr_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        rowsum_next    = rowsum_reg;
        lw_last_next   = lw_last_reg;
        lw_addr_next   = lw_addr_reg;
        lw_sum_next    = lw_sum_reg;
        lw_row0_next   = lw_row0_reg;
        top_next       = top_reg;
        bot_next       = bot_reg;
        wcnt_next      = wcnt_reg;
        total_next     = total_reg;
        vb_next        = issue;
        b_clear_next   = (state_reg == ST_CLEAR);
        b_top0_next    = (top_reg == '0);
        vc_next        = vb_reg && !b_clear_reg;
        s_c_next       = s_b;
        sk_c_next      = sk_b;
        ge_c_next      = ge_b;
        fwd_valid_next = vc_reg;
        fwd_addr_next  = s_c_reg;
        fwd_data_next  = CNW'(cnt_s + 1'b1);
        out_valid_next = out_valid_reg && !count_out.ready;
        out_data_next  = out_data_reg;

        if (state_reg == ST_INIT)
            init_addr_next = PW'(init_addr_reg + 1'b1);

        if (cell_acc)
        begin
            lw_addr_next = {row_reg, col_reg};
            lw_row0_next = (row_reg == '0);
            lw_sum_next  = rowsum_inc;
            lw_last_next = (row_reg == rows_m1) && (col_reg == cols_m1);
            if (col_reg == cols_m1)
            begin
                col_next    = '0;
                rowsum_next = '0;
                row_next    = (row_reg == rows_m1) ? '0 : RIW'(row_reg + 1'b1);
            end
            else
            begin
                col_next    = CIW'(col_reg + 1'b1);
                rowsum_next = rowsum_inc;
            end
        end
        if (cfg.restart)
        begin
            row_next    = '0;
            col_next    = '0;
            rowsum_next = '0;
        end

        if ((state_reg == ST_LWR) && lw_last_reg)
        begin
            top_next   = '0;
            bot_next   = '0;
            wcnt_next  = '0;
            total_next = '0;
        end

        if (issue)
            wcnt_next = col_last ? '0 : CIW'(wcnt_reg + 1'b1);

        if (vc_reg && ge_c_reg)
            total_next = total_reg + COUNT_W'(cnt_k);

        // next row pair once the clear pass is done
        if ((state_reg == ST_CDRAIN) && !vb_reg && !pair_last)
        begin
            if (bot_reg == rows_m1)
            begin
                top_next = RIW'(top_reg + 1'b1);
                bot_next = RIW'(top_reg + 1'b1);
            end
            else
            begin
                bot_next = RIW'(bot_reg + 1'b1);
            end
        end

        if ((state_reg == ST_EMIT) && out_free)
        begin
            out_valid_next = 1'b1;
            out_data_next  = total_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            init_addr_reg <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            rowsum_reg    <= '0;
            lw_last_reg   <= 1'b0;
            top_reg       <= '0;
            bot_reg       <= '0;
            wcnt_reg      <= '0;
            vb_reg        <= 1'b0;
            vc_reg        <= 1'b0;
            fwd_valid_reg <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_addr_reg <= init_addr_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            rowsum_reg    <= rowsum_next;
            lw_last_reg   <= lw_last_next;
            top_reg       <= top_next;
            bot_reg       <= bot_next;
            wcnt_reg      <= wcnt_next;
            vb_reg        <= vb_next;
            vc_reg        <= vc_next;
            fwd_valid_reg <= fwd_valid_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lw_addr_reg  <= lw_addr_next;
        lw_sum_reg   <= lw_sum_next;
        lw_row0_reg  <= lw_row0_next;
        b_clear_reg  <= b_clear_next;
        b_top0_reg   <= b_top0_next;
        s_c_reg      <= s_c_next;
        sk_c_reg     <= sk_c_next;
        ge_c_reg     <= ge_c_next;
        fwd_addr_reg <= fwd_addr_next;
        fwd_data_reg <= fwd_data_next;
        out_data_reg <= out_data_next;
    end

endmodule

### design/csk_checker.sv
// ----------------------------------------------------------------------------
// csk_checker: port-level checks for count_subgrids_with_sum_k
// Watches the cell and count channels; bound to the top level.
// ----------------------------------------------------------------------------
module csk_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [csk_pkg::COUNT_W-1:0] out_count
);
    import csk_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_count))
        else $error("result beat dropped or changed while stalled");

    // each accepted cell is followed by its write-back, when no cell is taken
    a_cell_gap: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("cell accepted during prefix write-back");

    // a result never follows a cell beat directly
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result raised right after a cell beat");

    // results come out of the count phase, when cells are not taken
    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready))
        else $error("result raised while loading");

endmodule

bind count_subgrids_with_sum_k csk_checker u_csk_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .out_valid (count_out.valid),
    .out_ready (count_out.ready),
    .out_count (count_out.subgrid_count)
);

### sim/tb_count_subgrids_with_sum_k.sv
// ----------------------------------------------------------------------------
// tb_count_subgrids_with_sum_k: self-checking bench for the subgrid counter
// Streams binary grids cell by cell, writes the size and target registers
// over APB between grids, and checks every count beat. Each count is checked
// against an in-bench prefix-sum counter, or against a hand-typed value for
// the corner rows.
// ----------------------------------------------------------------------------
module tb_count_subgrids_with_sum_k;
    timeunit 1ns;
    timeprecision 1ps;

    import csk_pkg::*;

    localparam int MR        = MAX_ROWS_DEF;
    localparam int MC        = MAX_COLS_DEF;
    localparam int SUM_DEPTH = MR * MC + 1;

    // The longest sweep here, a 64x2 strip, keeps both channels quiet
    // while its 2080 row pairs are counted, and the reset clearing pass is
    // quiet too. Allow several times the longer of the two before
    // declaring a hang.
    localparam int QUIET_LIMIT = 100_000;

    // Stop condition for the random part.
    localparam int RAND_CELLS  = 520;

    // Cycles to let the load pipeline drain before a register write.
    localparam int LOAD_DRAIN = 16;

    localparam int PLAN_LEN = 19;

    typedef enum int {
        FILL_ZERO,
        FILL_ONE,
        FILL_CHECK,
        FILL_RAND
    } fill_t;

    // One directed grid: optional partial load under the old sizes, optional
    // register setup, then a complete grid. want < 0 means the count comes
    // from the prefix-sum counter.
    typedef struct {
        bit          setup;
        int          drop;
        logic [31:0] rows;
        logic [31:0] cols;
        logic [31:0] target;
        fill_t       fill;
        int          density;
        int          want;
    } grid_case_t;

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    csk_cell_if  cell_ch ();
    csk_count_if cnt_ch ();

    count_subgrids_with_sum_k #(
        .MAX_ROWS (MR),
        .MAX_COLS (MC)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cell_in   (cell_ch),
        .count_out (cnt_ch)
    );

    // ------------------------------------------------------------------------
    // Prefix-sum counter: bench-side copy of the block state
    // ------------------------------------------------------------------------
    logic [TARGET_W-1:0] pfx      [0:MR][0:MC];
    logic [GRID_W-1:0]   tally    [0:SUM_DEPTH-1];
    logic [TARGET_W-1:0] col_sums [0:MC-1];
    logic [GRID_W-1:0]   cfg_rows;
    logic [GRID_W-1:0]   cfg_cols;
    logic [TARGET_W-1:0] cfg_target;
    int unsigned         at_row;
    int unsigned         at_col;

    // Counts still owed by the block, oldest first.
    logic [COUNT_W-1:0]  count_due [$];

    grid_case_t plan [0:PLAN_LEN-1];

    int  mismatches   = 0;
    int  cells_sent   = 0;
    int  pinned       = -1;   // typed count for the current directed row
    bit  tx_calm      = 1'b0; // sender runs with no gaps
    bit  rx_calm      = 1'b0; // receiver runs with no stalls

    // Out-of-range sizes: zero acts as one, above the capacity acts as it.
    function automatic int unsigned span(input logic [GRID_W-1:0] v, input int unsigned cap);
        if (v == 0)
            return 1;
        if (v > cap)
            return cap;
        return v;
    endfunction

    function automatic int unsigned grid_cells();
        return span(cfg_rows, MR) * span(cfg_cols, MC);
    endfunction

    function automatic void predictor_reset();
        for (int r = 0; r <= MR; r++)
            for (int c = 0; c <= MC; c++)
                pfx[r][c] = '0;
        for (int s = 0; s < SUM_DEPTH; s++)
            tally[s] = '0;
        tally[0] = GRID_W'(1);
        for (int w = 0; w < MC; w++)
            col_sums[w] = '0;
        cfg_rows   = GRID_ROWS_RST;
        cfg_cols   = GRID_COLS_RST;
        cfg_target = TARGET_SUM_RST;
        at_row     = 1;
        at_col     = 1;
    endfunction

    // Register value as stored: only the low bits of the write data count.
    function automatic logic [APB_DW-1:0] reg_view(input reg_idx_t idx, input logic [31:0] v);
        case (idx)
            REG_GRID_ROWS:  return APB_DW'(v[GRID_W-1:0]);
            REG_GRID_COLS:  return APB_DW'(v[GRID_W-1:0]);
            REG_TARGET_SUM: return APB_DW'(v[TARGET_W-1:0]);
            default:        return '0;
        endcase
    endfunction

    // Any write to a listed register restarts loading at the first cell.
    function automatic void apply_reg(input reg_idx_t idx, input logic [31:0] v);
        case (idx)
            REG_GRID_ROWS:  cfg_rows   = v[GRID_W-1:0];
            REG_GRID_COLS:  cfg_cols   = v[GRID_W-1:0];
            REG_TARGET_SUM: cfg_target = v[TARGET_W-1:0];
            default:        return;
        endcase
        at_row = 1;
        at_col = 1;
    endfunction

    // Walk every row pair top <= bot, sweep columns, and count earlier column
    // prefixes whose sum is exactly target lower. The table is put back to
    // its reset shape after each pair.
    function automatic logic [COUNT_W-1:0] tally_subgrids(input int unsigned rows,
                                                          input int unsigned cols);
        logic [COUNT_W-1:0] total;
        int unsigned        s;
        total = '0;
        for (int unsigned top = 1; top <= rows; top++)
        begin
            for (int unsigned bot = top; bot <= rows; bot++)
            begin
                for (int unsigned w = 1; w <= cols; w++)
                begin
                    s = pfx[bot][w] - pfx[top-1][w];
                    if (s >= SUM_DEPTH)
                        s = SUM_DEPTH - 1;
                    col_sums[w-1] = TARGET_W'(s);
                    if (s >= cfg_target)
                        total = total + COUNT_W'(tally[s - cfg_target]);
                    tally[s] = tally[s] + 1'b1;
                end
                for (int unsigned w = 0; w < cols; w++)
                    tally[col_sums[w]] = '0;
                tally[0] = GRID_W'(1);
            end
        end
        return total;
    endfunction

    // One accepted cell: update the prefix store, and on the last cell of
    // the grid produce the count and rewind the load position.
    task automatic load_cell(input logic b, output bit fin, output logic [COUNT_W-1:0] cnt);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        rows = span(cfg_rows, MR);
        cols = span(cfg_cols, MC);
        fin  = 1'b0;
        cnt  = '0;
        if (at_row < 1 || at_row > rows)
            at_row = 1;
        if (at_col < 1 || at_col > cols)
            at_col = 1;
        r = at_row;
        c = at_col;
        pfx[r][c] = TARGET_W'(int'(b) + pfx[r-1][c] + pfx[r][c-1] - pfx[r-1][c-1]);
        if (c < cols)
        begin
            at_col = c + 1;
            return;
        end
        at_col = 1;
        if (r < rows)
        begin
            at_row = r + 1;
            return;
        end
        cnt    = tally_subgrids(rows, cols);
        fin    = 1'b1;
        at_row = 1;
        at_col = 1;
    endtask

    task automatic report_miss(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t ns: %s", $realtime, what);
    endtask

    // ------------------------------------------------------------------------
    // Cell channel driver
    // ------------------------------------------------------------------------
    // Called at a rising edge. Valid is only dropped when a gap follows, so
    // back-to-back beats never see a low and a high in the same step.
    task automatic send_cell(input logic b, input int gap);
        bit                 fin;
        logic [COUNT_W-1:0] cnt;
        if (gap > 0)
        begin
            cell_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cell_ch.valid    <= 1'b1;
        cell_ch.cell_bit <= b;
        do @(posedge clk); while (cell_ch.ready !== 1'b1);
        // beat taken at this edge
        cells_sent++;
        load_cell(b, fin, cnt);
        if (fin)
            count_due = {count_due, (pinned >= 0 ? COUNT_W'(pinned) : cnt)};
    endtask

    function automatic int draw_gap();
        return tx_calm ? 0 : int'($urandom_range(0, 15));
    endfunction

    task automatic send_grid(input fill_t fill, input int density);
        int unsigned rows;
        int unsigned cols;
        logic        b;
        rows = span(cfg_rows, MR);
        cols = span(cfg_cols, MC);
        for (int unsigned r = 0; r < rows; r++)
        begin
            for (int unsigned c = 0; c < cols; c++)
            begin
                case (fill)
                    FILL_ZERO:  b = 1'b0;
                    FILL_ONE:   b = 1'b1;
                    FILL_CHECK: b = 1'((r + c) % 2);
                    default:    b = ($urandom_range(0, 99) < density);
                endcase
                send_cell(b, draw_gap());
            end
        end
    endtask

    // Partial grid, to be cut short by a register write.
    task automatic send_partial(input int n);
        for (int i = 0; i < n; i++)
            send_cell(1'($urandom_range(0, 1)), draw_gap());
    endtask

    // Hold off the sender until every owed count has come back, then let the
    // load pipeline finish its last write-back.
    task automatic settle();
        cell_ch.valid <= 1'b0;
        do @(posedge clk); while (count_due.size() != 0);
        repeat (LOAD_DRAIN) @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // APB: write, then read back through a back-to-back transfer
    // ------------------------------------------------------------------------
    task automatic set_reg(input reg_idx_t idx, input logic [31:0] v);
        logic [APB_DW-1:0] got;
        // write setup
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= v;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        apply_reg(idx, v);
        // read setup, psel stays high
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        got = prdata;
        if (got !== reg_view(idx, v))
            report_miss($sformatf("register %0d readback: expected %0d, got %0d",
                                  idx, reg_view(idx, v), got));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_sizes(input logic [31:0] rv, input logic [31:0] cv,
                               input logic [31:0] tv);
        set_reg(REG_GRID_ROWS, rv);
        set_reg(REG_GRID_COLS, cv);
        set_reg(REG_TARGET_SUM, tv);
    endtask

    // Random sizes: mostly small grids, a few medium, long thin strips for the
    // clamped extremes, and zero sizes. Never a large square, which would be
    // slow to sweep.
    task automatic pick_config();
        int          shape;
        logic [31:0] rv;
        logic [31:0] cv;
        logic [31:0] tv;
        int unsigned cells;
        shape = $urandom_range(0, 24);
        if (shape < 20)
        begin
            rv = $urandom_range(1, 8);
            cv = $urandom_range(1, 8);
        end
        else if (shape < 22)
        begin
            rv = $urandom_range(9, 20);
            cv = $urandom_range(1, 20);
        end
        else if (shape == 22)
        begin
            rv = $urandom_range(64, 127);
            cv = $urandom_range(1, 2);
        end
        else if (shape == 23)
        begin
            rv = $urandom_range(1, 2);
            cv = $urandom_range(64, 127);
        end
        else
        begin
            rv = 0;
            cv = $urandom_range(0, 8);
            if ($urandom_range(0, 1) == 1)
            begin
                rv = cv;
                cv = 0;
            end
        end
        cells = span(rv[GRID_W-1:0], MR) * span(cv[GRID_W-1:0], MC);
        if ($urandom_range(0, 9) == 0)
            tv = $urandom_range(0, 8191);
        else
            tv = $urandom_range(0, cells);
        // junk above the register width is dropped by the block
        if ($urandom_range(0, 7) == 0)
            rv = rv | ($urandom & 32'hFFFF_FF80);
        if ($urandom_range(0, 7) == 0)
            cv = cv | ($urandom & 32'hFFFF_FF80);
        if ($urandom_range(0, 7) == 0)
            tv = tv | ($urandom & 32'hFFFF_E000);
        write_sizes(rv, cv, tv);
    endtask

    // ------------------------------------------------------------------------
    // Clock and reset
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Count channel: random stalls, every beat checked in order
    // ------------------------------------------------------------------------
    initial
    begin : count_drain
        int                 stall;
        logic [COUNT_W-1:0] got;
        logic [COUNT_W-1:0] want;
        cnt_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = rx_calm ? 0 : int'($urandom_range(0, 15));
            if ($urandom_range(0, 7) == 0)
                rx_calm = !rx_calm;
            if (stall > 0)
            begin
                cnt_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            cnt_ch.ready <= 1'b1;
            do @(posedge clk); while (cnt_ch.valid !== 1'b1);
            // beat taken at this edge
            got = cnt_ch.subgrid_count;
            if (count_due.size() == 0)
                report_miss($sformatf("count beat %0d with none owed", got));
            else
            begin
                want = count_due.pop_front();
                if (got !== want)
                    report_miss($sformatf("subgrid_count: expected %0d, got %0d", want, got));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Hang detector: cycles with no beat on either channel
    // ------------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((cell_ch.valid === 1'b1 && cell_ch.ready === 1'b1) ||
                (cnt_ch.valid === 1'b1 && cnt_ch.ready === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        rst_n            <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        cell_ch.valid    <= 1'b0;
        cell_ch.cell_bit <= 1'b0;
        predictor_reset();

        // Directed rows. Typed counts are the ones that follow from the grid
        // shape alone: all-zero grids with target zero count every subgrid,
        // all-one grids with the full cell count as target count one.
        plan = '{
            // all-zero 4x4, target 0: every subgrid counts
            '{1'b1, 0, 32'd4,   32'd4,   32'd0,    FILL_ZERO,  0,  100},
            '{1'b1, 0, 32'd1,   32'd1,   32'd0,    FILL_ZERO,  0,  1},
            '{1'b1, 0, 32'd1,   32'd1,   32'd0,    FILL_ONE,   0,  0},
            // zero sizes act as a single cell
            '{1'b1, 0, 32'd0,   32'd0,   32'd1,    FILL_ONE,   0,  1},
            // target beyond the cell count
            '{1'b1, 0, 32'd2,   32'd3,   32'd4096, FILL_ONE,   0,  0},
            '{1'b1, 0, 32'd2,   32'd3,   32'd8191, FILL_ONE,   0,  0},
            // sizes above the capacity clamp to it
            '{1'b1, 0, 32'd127, 32'd1,   32'd0,    FILL_ZERO,  0,  2080},
            '{1'b1, 0, 32'd1,   32'd127, 32'd1,    FILL_ONE,   0,  64},
            '{1'b1, 0, 32'd64,  32'd2,   32'd128,  FILL_ONE,   0,  1},
            '{1'b1, 0, 32'd2,   32'd64,  32'd128,  FILL_ONE,   0,  1},
            '{1'b1, 0, 32'd4,   32'd4,   32'd0,    FILL_ONE,   0,  0},
            '{1'b1, 0, 32'd3,   32'd3,   32'd9,    FILL_ONE,   0,  1},
            // five cells loaded, then a write drops them
            '{1'b1, 5, 32'd3,   32'd3,   32'd0,    FILL_ZERO,  0,  36},
            '{1'b1, 0, 32'd5,   32'd7,   32'd3,    FILL_RAND,  50, -1},
            '{1'b1, 0, 32'd8,   32'd8,   32'd2,    FILL_CHECK, 0,  -1},
            '{1'b1, 0, 32'd6,   32'd6,   32'd0,    FILL_RAND,  30, -1},
            '{1'b1, 0, 32'd7,   32'd5,   32'd1,    FILL_RAND,  10, -1},
            // next grid right after a count, no register write
            '{1'b0, 0, 32'd7,   32'd5,   32'd1,    FILL_RAND,  70, -1},
            // junk in the upper write bits
            '{1'b1, 0, 32'hFFFF_FF83, 32'h0000_0104, 32'hFFFF_E002, FILL_RAND, 50, -1}
        };

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        // clearing pass: the cell channel opens when the table is filled
        do @(posedge clk); while (cell_ch.ready !== 1'b1);

        foreach (plan[i])
        begin
            if (plan[i].drop > 0)
                send_partial(plan[i].drop);
            if (plan[i].setup)
            begin
                settle();
                write_sizes(plan[i].rows, plan[i].cols, plan[i].target);
            end
            pinned  = plan[i].want;
            tx_calm = (i % 4 == 3);
            send_grid(plan[i].fill, plan[i].density);
        end
        pinned = -1;

        // Random grids. Mostly complete grids with random content; some
        // reconfigurations cut a grid short first.
        cells_sent = 0;
        while (cells_sent < RAND_CELLS)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                if ($urandom_range(0, 2) == 0 && grid_cells() > 1)
                    send_partial($urandom_range(1, grid_cells() - 1));
                settle();
                pick_config();
            end
            else if ($urandom_range(0, 7) == 0)
                settle();
            tx_calm = ($urandom_range(0, 3) == 0);
            send_grid(FILL_RAND, $urandom_range(0, 100));
        end

        // drain: all counts back, then a margin for stray beats
        settle();
        repeat (64) @(posedge clk);
        if (mismatches == 0 && count_due.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
